### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk outside reset
`define SDP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication a |=> b checked on every rising edge of clk outside reset
`define SDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/sdp_pkg.sv
// ----------------------------------------------------------------------------
// sdp_pkg
// widths, register indexes and constants of the disparity reprojection block
// ----------------------------------------------------------------------------
package sdp_pkg;

	localparam int COORD_W = 12;
	localparam int DISP_W  = 16;
	localparam int REG_W   = 16;
	localparam int DEPTH_W = 20;
	localparam int POINT_W = 24;
	localparam int COLOR_W = 8;

	localparam int BMM_W   = 26;
	localparam int NUM_W   = 42;
	localparam int QUO_W   = 24;
	localparam int SPLIT_W = 21;
	localparam int FRAC_W  = 16;

	localparam logic [9:0] BMM_SCALE = 10'd1000;

	typedef enum logic [2:0] {
		REG_FOCAL_X   = 3'd0,
		REG_FOCAL_Y   = 3'd1,
		REG_CENTER_X  = 3'd2,
		REG_CENTER_Y  = 3'd3,
		REG_BASELINE  = 3'd4,
		REG_MIN_DISP  = 3'd5,
		REG_MIN_DEPTH = 3'd6,
		REG_MAX_DEPTH = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic               valid;
		logic               keep;
		logic               neg_x;
		logic               neg_y;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} side_t;

endpackage

### hw/rtl/sdp_divider.sv
// ----------------------------------------------------------------------------
// sdp_divider
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module sdp_divider #(
	parameter int DW = 26,
	parameter int VW = 16,
	parameter int QW = 24
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [QW-1:0] quotient,
	output logic          overflow
);

	localparam int HW = DW - QW;
	localparam int CW = (HW > VW) ? HW : VW;

	logic [VW-1:0] rem_q [0:QW];
	logic [QW-1:0] lo_q  [0:QW];
	logic [QW-1:0] quo_q [0:QW];
	logic [VW-1:0] dsr_q [0:QW];
	logic          ovf_q [0:QW];

	logic [HW-1:0] hi;
	logic          ovf0;

	assign hi   = dividend[DW-1:QW];
	assign ovf0 = CW'(hi) >= CW'(divisor);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= ovf0 ? '0 : VW'(hi);
			lo_q[0]  <= dividend[QW-1:0];
			quo_q[0] <= '0;
			dsr_q[0] <= divisor;
			ovf_q[0] <= ovf0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [VW:0] trial;
		logic [VW:0] diff;
		logic        ge;

		assign trial = {rem_q[k], lo_q[k][QW-1]};
		assign diff  = trial - {1'b0, dsr_q[k]};
		assign ge    = trial >= {1'b0, dsr_q[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= ge ? diff[VW-1:0] : trial[VW-1:0];
				lo_q[k+1]  <= {lo_q[k][QW-2:0], 1'b0};
				quo_q[k+1] <= {quo_q[k][QW-2:0], ge};
				dsr_q[k+1] <= dsr_q[k];
				ovf_q[k+1] <= ovf_q[k];
			end
		end
	end

	assign quotient = quo_q[QW];
	assign overflow = ovf_q[QW];

endmodule

### hw/rtl/stereo_disparity_to_point.sv
// One pixel per clock enters and, once the pipeline is full, one point leaves per clock
// while the output is not stalled; each pixel passes three multiply stages, then
// the 25 register stages of the restoring dividers (depth, x and y; one load stage and
// 24 quotient-bit stages), then the output register. A pixel that fails the disparity,
// image-bound or depth window tests leaves a bubble and no output beat. A stall on the
// output freezes the whole pipeline, nothing is lost or repeated.
// ----------------------------------------------------------------------------
// stereo_disparity_to_point
// reprojects a disparity pixel to a coloured 3-d point in millimetres
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_disparity_to_point
	import sdp_pkg::*;
#(
	parameter int IMAGE_WIDTH_MAX  = 4096,
	parameter int IMAGE_HEIGHT_MAX = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pixel_column, pixel_row, raw_disparity, blue_in, green_in, red_in
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// point_x_mm, point_y_mm, point_z_mm, blue_out, green_out, red_out, zero pad
	output logic [95:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	localparam int LAT = QUO_W + 1;

	logic [REG_W-1:0]   focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [REG_W-1:0]   baseline_q, min_disp_q;
	logic [DEPTH_W-1:0] min_depth_q, max_depth_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q   <= 16'd11552;
			focal_y_q   <= 16'd11552;
			center_x_q  <= 16'd9936;
			center_y_q  <= 16'd2992;
			baseline_q  <= 16'd5243;
			min_disp_q  <= 16'd1;
			min_depth_q <= 20'd500;
			max_depth_q <= 20'd96000;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_FOCAL_X:   focal_x_q   <= cfg_data[REG_W-1:0];
				REG_FOCAL_Y:   focal_y_q   <= cfg_data[REG_W-1:0];
				REG_CENTER_X:  center_x_q  <= cfg_data[REG_W-1:0];
				REG_CENTER_Y:  center_y_q  <= cfg_data[REG_W-1:0];
				REG_BASELINE:  baseline_q  <= cfg_data[REG_W-1:0];
				REG_MIN_DISP:  min_disp_q  <= cfg_data[REG_W-1:0];
				REG_MIN_DEPTH: min_depth_q <= cfg_data;
				REG_MAX_DEPTH: max_depth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// input unpack
	logic [COORD_W-1:0] col, row;
	logic [DISP_W-1:0]  disp;
	logic [15:0]        scol, srow;
	logic               in_keep;

	assign col  = s_tdata[11:0];
	assign row  = s_tdata[23:12];
	assign disp = s_tdata[39:24];
	assign scol = {col, 4'b0000};
	assign srow = {row, 4'b0000};
	assign in_keep = ({1'b0, col} < 13'(IMAGE_WIDTH_MAX)) &&
		({1'b0, row} < 13'(IMAGE_HEIGHT_MAX)) &&
		(disp != '0) && (disp >= min_disp_q) && (focal_y_q != '0);

	// stage 1
	logic               v_s1, keep_s1, negx_s1, negy_s1;
	logic [15:0]        magx_s1, magy_s1;
	logic [DISP_W-1:0]  disp_s1;
	logic [BMM_W-1:0]   bmm_s1;
	logic [23:0]        color_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep_s1  <= in_keep;
			negx_s1  <= scol < center_x_q;
			negy_s1  <= srow < center_y_q;
			magx_s1  <= (scol < center_x_q) ? center_x_q - scol : scol - center_x_q;
			magy_s1  <= (srow < center_y_q) ? center_y_q - srow : srow - center_y_q;
			disp_s1  <= disp;
			bmm_s1   <= BMM_W'(baseline_q) * BMM_W'(BMM_SCALE);
			color_s1 <= s_tdata[63:40];
		end
	end

	// stage 2
	logic               v_s2, keep_s2, negx_s2, negy_s2;
	logic [15:0]        magy_s2;
	logic [NUM_W-1:0]   num_s2, px_s2;
	logic [35:0]        lo_s2, hi_s2;
	logic [31:0]        fyd_s2;
	logic [DISP_W-1:0]  disp_s2;
	logic [23:0]        color_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep_s2  <= keep_s1;
			negx_s2  <= negx_s1;
			negy_s2  <= negy_s1;
			magy_s2  <= magy_s1;
			num_s2   <= NUM_W'(focal_x_q) * NUM_W'(bmm_s1);
			px_s2    <= NUM_W'(magx_s1) * NUM_W'(bmm_s1);
			lo_s2    <= 36'(min_depth_q) * 36'(disp_s1);
			hi_s2    <= 36'(max_depth_q) * 36'(disp_s1);
			fyd_s2   <= 32'(focal_y_q) * 32'(disp_s1);
			disp_s2  <= disp_s1;
			color_s2 <= color_s1;
		end
	end

	// stage 3
	side_t              side_s3;
	logic [NUM_W-1:0]   num_s3, px_s3;
	logic [36:0]        pl_s3, ph_s3;
	logic [31:0]        fyd_s3;
	logic [DISP_W-1:0]  disp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (en) begin
			side_s3.valid <= v_s2;
			side_s3.keep  <= keep_s2 && ({10'b0, num_s2} > {lo_s2, 16'b0}) &&
				({10'b0, num_s2} < {hi_s2, 16'b0});
			side_s3.neg_x <= negx_s2;
			side_s3.neg_y <= negy_s2;
			side_s3.blue  <= color_s2[7:0];
			side_s3.green <= color_s2[15:8];
			side_s3.red   <= color_s2[23:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3  <= num_s2;
			px_s3   <= px_s2;
			pl_s3   <= 37'(magy_s2) * 37'(num_s2[SPLIT_W-1:0]);
			ph_s3   <= 37'(magy_s2) * 37'(num_s2[NUM_W-1:SPLIT_W]);
			fyd_s3  <= fyd_s2;
			disp_s3 <= disp_s2;
		end
	end

	// divider stages
	logic [57:0] ay;
	assign ay = 58'(pl_s3) + {ph_s3[36:0], 21'b0};

	logic [QUO_W-1:0] qx, qy, qz;
	logic             ox, oy, oz;

	sdp_divider #(.DW(NUM_W - FRAC_W), .VW(DISP_W), .QW(QUO_W)) u_div_x (
		.clk      (clk),
		.en       (en),
		.dividend (px_s3[NUM_W-1:FRAC_W]),
		.divisor  (disp_s3),
		.quotient (qx),
		.overflow (ox)
	);

	sdp_divider #(.DW(58 - FRAC_W), .VW(32), .QW(QUO_W)) u_div_y (
		.clk      (clk),
		.en       (en),
		.dividend (ay[57:FRAC_W]),
		.divisor  (fyd_s3),
		.quotient (qy),
		.overflow (oy)
	);

	sdp_divider #(.DW(NUM_W - FRAC_W), .VW(DISP_W), .QW(QUO_W)) u_div_z (
		.clk      (clk),
		.en       (en),
		.dividend (num_s3[NUM_W-1:FRAC_W]),
		.divisor  (disp_s3),
		.quotient (qz),
		.overflow (oz)
	);

	side_t side_d [0:LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				side_d[k] <= '0;
			end
		end else if (en) begin
			side_d[0] <= side_s3;
			for (int k = 1; k < LAT; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	function automatic logic [POINT_W-1:0] sat_point(
		input logic [QUO_W-1:0] q,
		input logic             ovf,
		input logic             neg
	);
		logic [POINT_W-1:0] r;
		if (neg) begin
			if (ovf || (q > 24'h800000)) r = 24'h800000;
			else r = 24'h000000 - q;
		end else begin
			if (ovf || q[QUO_W-1]) r = 24'h7fffff;
			else r = q;
		end
		return r;
	endfunction

	// output stage
	side_t side_end;
	assign side_end = side_d[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= side_end.valid && side_end.keep;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {4'b0000, side_end.red, side_end.green, side_end.blue,
				qz[DEPTH_W-1:0], sat_point(qy, oy, side_end.neg_y),
				sat_point(qx, ox, side_end.neg_x)};
		end
	end

	`SDP_ASSERT(a_stall_only_when_full, !s_tready |-> m_tvalid, "input stalled with empty output")
	`SDP_ASSERT_NEXT(a_stall_holds_s1, !en, $stable(v_s1), "stage one moved during stall")
	`SDP_ASSERT_NEXT(a_stall_holds_tail, !en, $stable(side_d[LAT-1]), "tail moved during stall")
	`SDP_ASSERT(a_depth_fits, side_end.valid && side_end.keep |-> !oz && (qz[QUO_W-1:DEPTH_W] == '0), "depth out of range")

endmodule
